// File: sv/bilp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilp_pkg
// Shared types and constants for the integer literal parser.
// ----------------------------------------------------------------------------
package bilp_pkg;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_UH    = 8'h48;
    localparam logic [7:0] CHAR_UO    = 8'h4F;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'd32;

    // Character classes
    typedef logic [2:0] char_class_t;
    localparam char_class_t CLS_OTHER = 3'd0;
    localparam char_class_t CLS_BLANK = 3'd1;
    localparam char_class_t CLS_AMP   = 3'd2;
    localparam char_class_t CLS_PLUS  = 3'd3;
    localparam char_class_t CLS_MINUS = 3'd4;
    localparam char_class_t CLS_LET_H = 3'd5;
    localparam char_class_t CLS_LET_O = 3'd6;
    localparam char_class_t CLS_DIGIT = 3'd7;  // 0-9 or A-F

    typedef struct packed {
        logic        first;
        char_class_t cls;
        logic        is_dec;
        logic        is_oct;
        logic [3:0]  dig_val;
    } char_item_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam int VALUE_W     = 32;
    localparam int SHORT_W     = 16;

endpackage : bilp_pkg
`default_nettype wire

// File: sv/bilp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilp_front
// Folds case and classifies each incoming byte for the parse engine.
// ----------------------------------------------------------------------------
module bilp_front
    import bilp_pkg::*;
(
    input  wire logic [7:0] char_code,
    input  wire logic       first_char,
    output char_item_t      item
);

    logic [7:0] c;

    always_comb begin
        c = char_code;
        if (char_code >= CHAR_LA && char_code <= CHAR_LZ) begin
            c = char_code - CASE_DIFF;
        end

        item.first   = first_char;
        item.is_dec  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        item.is_oct  = (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
        item.dig_val = 4'd0;
        item.cls     = CLS_OTHER;

        if (c != CHAR_NUL && c <= CHAR_SPACE) begin
            item.cls = CLS_BLANK;
        end else if (c == CHAR_AMP) begin
            item.cls = CLS_AMP;
        end else if (c == CHAR_PLUS) begin
            item.cls = CLS_PLUS;
        end else if (c == CHAR_MINUS) begin
            item.cls = CLS_MINUS;
        end else if (c == CHAR_UH) begin
            item.cls = CLS_LET_H;
        end else if (c == CHAR_UO) begin
            item.cls = CLS_LET_O;
        end else if (item.is_dec) begin
            item.cls     = CLS_DIGIT;
            item.dig_val = 4'(c - CHAR_ZERO);
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            item.cls     = CLS_DIGIT;
            item.dig_val = 4'(c - CHAR_UA + 8'd10);
        end
    end

endmodule : bilp_front
`default_nettype wire

// File: sv/bilp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilp_queue
// Two-entry queue of classified bytes between front and parse engine.
// ----------------------------------------------------------------------------
module bilp_queue
    import bilp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  char_item_t push_item,
    output logic       not_full,
    input  wire logic  pop,
    output char_item_t pop_item,
    output logic       not_empty
);

    char_item_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]     count_reg, count_next;
    logic                       do_push, do_pop;

    assign not_full  = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule : bilp_queue
`default_nettype wire

// File: sv/bilp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilp_back
// Parse engine: prefix, sign and digit state machine with output register.
// ----------------------------------------------------------------------------
module bilp_back
    import bilp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         item_valid,
    input  char_item_t        item,
    output logic              item_pop,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [47:0]       m_axis_tdata
);

    localparam logic [2:0] PH_DONE   = 3'd0;
    localparam logic [2:0] PH_BLANK  = 3'd1;
    localparam logic [2:0] PH_AMP    = 3'd2;
    localparam logic [2:0] PH_SIGN   = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    logic [2:0]         phase_reg, phase_next;
    logic [1:0]         radix_reg, radix_next;
    logic               neg_reg, neg_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg;

    logic [2:0]         phase;
    logic [1:0]         radix;
    logic               neg;
    logic [VALUE_W-1:0] acc, acc_mac, emit_val;
    logic               is_digit, do_sign, do_digit, emit;

    assign item_pop = item_valid && (!out_valid_reg || m_axis_tready);

    always_comb begin
        // a start flag restarts the parse on this very byte
        phase = item.first ? PH_BLANK  : phase_reg;
        radix = item.first ? RADIX_DEC : radix_reg;
        neg   = item.first ? 1'b0      : neg_reg;
        acc   = item.first ? '0        : acc_reg;

        case (radix)
            RADIX_HEX: begin
                is_digit = item.cls == CLS_DIGIT;
                acc_mac  = (acc << 4) + VALUE_W'(item.dig_val);
            end
            RADIX_OCT: begin
                is_digit = item.is_oct;
                acc_mac  = (acc << 3) + VALUE_W'(item.dig_val);
            end
            default: begin
                is_digit = item.is_dec;
                acc_mac  = (acc << 3) + (acc << 1) + VALUE_W'(item.dig_val);
            end
        endcase

        phase_next = phase;
        radix_next = radix;
        neg_next   = neg;
        acc_next   = acc;
        do_sign    = 1'b0;
        do_digit   = 1'b0;
        emit       = 1'b0;
        emit_val   = '0;

        unique case (phase)
            PH_BLANK: begin
                if (item.cls == CLS_AMP) begin
                    phase_next = PH_AMP;
                end else if (item.cls != CLS_BLANK) begin
                    do_sign = 1'b1;
                end
            end
            PH_AMP: begin
                if (item.cls == CLS_LET_H) begin
                    radix_next = RADIX_HEX;
                    phase_next = PH_SIGN;
                end else if (item.cls == CLS_LET_O) begin
                    radix_next = RADIX_OCT;
                    phase_next = PH_SIGN;
                end else begin
                    emit       = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_SIGN:   do_sign  = 1'b1;
            PH_DIGITS: do_digit = 1'b1;
            default: begin
            end
        endcase

        if (do_sign) begin
            if (item.cls == CLS_MINUS) begin
                neg_next   = 1'b1;
                phase_next = PH_DIGITS;
            end else if (item.cls == CLS_PLUS) begin
                phase_next = PH_DIGITS;
            end else begin
                do_digit = 1'b1;
            end
        end

        if (do_digit) begin
            if (is_digit) begin
                acc_next   = acc_mac;
                phase_next = PH_DIGITS;
            end else begin
                emit       = 1'b1;
                emit_val   = neg ? (VALUE_W'(0) - acc) : acc;
                phase_next = PH_DONE;
            end
        end

        out_valid_next = out_valid_reg;
        if (item_pop && emit) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_DONE;
            radix_reg     <= RADIX_DEC;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (item_pop) begin
                phase_reg <= phase_next;
                radix_reg <= radix_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop && emit) begin
            out_value_reg <= emit_val;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_value_reg[SHORT_W-1:0], out_value_reg};

endmodule : bilp_back
`default_nettype wire

// File: sv/basic_integer_literal_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// basic_integer_literal_parser_core
// Streams a NUL-terminated string and returns its integer value.
// ----------------------------------------------------------------------------
// Input: one byte per transfer on s_axis; tuser marks the first byte of a
// string and restarts the parse (an unfinished number is dropped).
// Leading blanks, an optional &H / &O prefix and a sign are taken, then
// digits; the first non-digit ends the number and gives one transfer on
// m_axis with the wrapped 32-bit value and its low 16 bits. Bytes after
// that are ignored until the next first-byte flag.
// Throughput: one byte per cycle while m_axis is not stalled. With the
// output free, the terminating byte, once accepted, goes through the
// two-entry queue into the engine and the one-result register to m_axis.
// Reset (aresetn low, synchronous) empties the queue and the output
// register and leaves the parser idle, waiting for a first byte.
// When m_axis stalls with a result pending, the engine holds and the byte
// queue fills; s_axis_tready drops once both queue entries are taken.
// ----------------------------------------------------------------------------
module basic_integer_literal_parser_core
    import bilp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic [0:0]  s_axis_tuser,   // [0] first_char
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // [31:0] value_32, [47:32] value_16
);

    char_item_t front_item, queue_item;
    logic       queue_not_full, queue_not_empty, queue_pop;

    bilp_front u_front (
        .char_code  (s_axis_tdata),
        .first_char (s_axis_tuser[0]),
        .item       (front_item)
    );

    assign s_axis_tready = queue_not_full;

    bilp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_axis_tvalid),
        .push_item (front_item),
        .not_full  (queue_not_full),
        .pop       (queue_pop),
        .pop_item  (queue_item),
        .not_empty (queue_not_empty)
    );

    bilp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (queue_not_empty),
        .item          (queue_item),
        .item_pop      (queue_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule : basic_integer_literal_parser_core
`default_nettype wire
